// ===== sv/dcst_pkg.sv =====
// Shared types, codes and constants for the document code stream tokenizer.
// Used by the parser, the result register and the top of the block; depends on nothing.
package dcst_pkg;

   localparam logic [7:0] DOC_END_LO   = 8'h00;
   localparam logic [7:0] DOC_END_HI   = 8'hFF;
   localparam logic [7:0] HARD_RETURN  = 8'h0A;
   localparam logic [7:0] SOFT_RETURN  = 8'h0D;
   localparam logic [7:0] HARD_HYPHEN  = 8'hA9;
   localparam logic [7:0] EXT_CHAR     = 8'hC0;
   localparam logic [7:0] FIXED_FIRST  = 8'd192;
   localparam logic [7:0] FIXED_LAST   = 8'd207;
   localparam logic [7:0] VAR_FIRST    = 8'd208;
   localparam logic [7:0] TEXT_FIRST   = 8'd32;
   localparam logic [7:0] TEXT_LAST    = 8'd127;
   localparam logic [7:0] CHAR_SPACE   = 8'h20;
   localparam logic [7:0] CHAR_HYPHEN  = 8'h2D;
   localparam logic [7:0] CHAR_APOS    = 8'h27;
   localparam logic [7:0] EXT_CHARSET  = 8'd4;
   localparam logic [7:0] EXT_DASH     = 8'd33;
   localparam logic [7:0] EXT_APOS     = 8'd28;

   typedef enum logic [2:0] {
      KIND_TEXT     = 3'd0,
      KIND_PARA_END = 3'd1,
      KIND_FUNC_END = 3'd2,
      KIND_BODY     = 3'd3,
      KIND_DOC_END  = 3'd4
   } kind_type;

   typedef enum logic [2:0] {
      PH_IDLE   = 3'd0,
      PH_FBODY  = 3'd1,
      PH_FTRAIL = 3'd2,
      PH_VSUB   = 3'd3,
      PH_VLENLO = 3'd4,
      PH_VLENHI = 3'd5,
      PH_VBODY  = 3'd6,
      PH_DONE   = 3'd7
   } phase_type;

   typedef struct packed {
      logic [2:0]  kind;
      logic [7:0]  char_code;
      logic [7:0]  func_code;
      logic [7:0]  sub_code;
      logic [15:0] body_index;
      logic [7:0]  body_byte;
      logic        func_last;
   } rsp_type;

   // Body length of the fixed-length functions, indexed by code minus 192.
   function automatic logic [3:0] fixed_len(input logic [3:0] sel);
      logic [3:0] len;
      case (sel)
         4'd0:    len = 4'd2;
         4'd1:    len = 4'd7;
         4'd2:    len = 4'd9;
         4'd3:    len = 4'd1;
         4'd4:    len = 4'd1;
         4'd5:    len = 4'd3;
         4'd6:    len = 4'd4;
         4'd7:    len = 4'd5;
         4'd8:    len = 4'd2;
         4'd9:    len = 4'd3;
         4'd10:   len = 4'd4;
         4'd11:   len = 4'd4;
         4'd12:   len = 4'd6;
         4'd13:   len = 4'd8;
         4'd14:   len = 4'd8;
         4'd15:   len = 4'd10;
         default: len = 4'd0;
      endcase
      return len;
   endfunction

endpackage

// ===== sv/dcst_stream_if.sv =====
// Valid/ready channel interfaces for the tokenizer: byte input and token output.
// Depends on nothing but plain logic types.
interface dcst_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] byte_in;

   modport source (output valid, output byte_in, input ready);
   modport sink   (input valid, input byte_in, output ready);
endinterface

interface dcst_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  kind;
   logic [7:0]  char_code;
   logic [7:0]  func_code;
   logic [7:0]  sub_code;
   logic [15:0] body_index;
   logic [7:0]  body_byte;
   logic        func_last;

   modport source (output valid, output kind, output char_code, output func_code,
                   output sub_code, output body_index, output body_byte,
                   output func_last, input ready);
   modport sink   (input valid, input kind, input char_code, input func_code,
                   input sub_code, input body_index, input body_byte,
                   input func_last, output ready);
endinterface

// ===== sv/dcst_in_reg.sv =====
// Input register of the tokenizer: holds one accepted byte until it is parsed.
// Depends on nothing outside this file.
module dcst_in_reg (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_byte,
   input  logic       take,
   output logic       hold_valid,
   output logic [7:0] hold_byte
);

   logic       vld_ff, vld_in;
   logic [7:0] byte_ff;

   // A new beat may enter whenever the held byte is empty or leaves this cycle.
   assign req_ready = !vld_ff || take;
   assign vld_in    = (req_valid && req_ready) || (vld_ff && !take);

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         byte_ff <= req_byte;
      end
   end

   assign hold_valid = vld_ff;
   assign hold_byte  = byte_ff;

endmodule

// ===== sv/dcst_parser.sv =====
// Tokenizer state machine: parse state registers and the per-byte decode logic.
// Depends on dcst_pkg for phase and kind codes, the result struct and the length table.
module dcst_parser (
   input  logic             clock,
   input  logic             reset,
   input  logic             step,
   input  logic [7:0]       byte_in,
   output logic             emit,
   output dcst_pkg::rsp_type result
);

   dcst_pkg::phase_type phase_ff, phase_in;
   logic [7:0]  code_ff, code_in;
   logic [7:0]  sub_ff, sub_in;
   logic [7:0]  len_lo_ff, len_lo_in;
   logic [15:0] left_ff, left_in;
   logic [15:0] pos_ff, pos_in;
   logic [7:0]  ext_code_ff, ext_code_in;
   logic [7:0]  ext_set_ff, ext_set_in;
   logic [15:0] left_dec;
   logic [15:0] var_len;

   assign left_dec = left_ff - 16'd1;
   assign var_len  = {byte_in, len_lo_ff};

   // Next state.
   always_comb begin
      phase_in    = phase_ff;
      code_in     = code_ff;
      sub_in      = sub_ff;
      len_lo_in   = len_lo_ff;
      left_in     = left_ff;
      pos_in      = pos_ff;
      ext_code_in = ext_code_ff;
      ext_set_in  = ext_set_ff;
      case (phase_ff)
         dcst_pkg::PH_IDLE: begin
            if (byte_in == dcst_pkg::DOC_END_LO || byte_in == dcst_pkg::DOC_END_HI) begin
               phase_in = dcst_pkg::PH_DONE;
            end else if (byte_in >= dcst_pkg::FIXED_FIRST && byte_in <= dcst_pkg::FIXED_LAST) begin
               code_in     = byte_in;
               sub_in      = 8'd0;
               left_in     = {12'd0, dcst_pkg::fixed_len(byte_in[3:0])};
               pos_in      = 16'd0;
               ext_code_in = 8'd0;
               ext_set_in  = 8'd0;
               phase_in    = dcst_pkg::PH_FBODY;
            end else if (byte_in >= dcst_pkg::VAR_FIRST) begin
               code_in  = byte_in;
               sub_in   = 8'd0;
               phase_in = dcst_pkg::PH_VSUB;
            end
         end
         dcst_pkg::PH_FBODY: begin
            if (pos_ff == 16'd0) ext_code_in = byte_in;
            if (pos_ff == 16'd1) ext_set_in = byte_in;
            pos_in  = pos_ff + 16'd1;
            left_in = left_dec;
            if (left_dec == 16'd0) phase_in = dcst_pkg::PH_FTRAIL;
         end
         dcst_pkg::PH_FTRAIL: begin
            phase_in = dcst_pkg::PH_IDLE;
         end
         dcst_pkg::PH_VSUB: begin
            sub_in   = byte_in;
            phase_in = dcst_pkg::PH_VLENLO;
         end
         dcst_pkg::PH_VLENLO: begin
            len_lo_in = byte_in;
            phase_in  = dcst_pkg::PH_VLENHI;
         end
         dcst_pkg::PH_VLENHI: begin
            left_in  = var_len;
            pos_in   = 16'd0;
            phase_in = (var_len == 16'd0) ? dcst_pkg::PH_IDLE : dcst_pkg::PH_VBODY;
         end
         dcst_pkg::PH_VBODY: begin
            pos_in  = pos_ff + 16'd1;
            left_in = left_dec;
            if (left_dec == 16'd0) phase_in = dcst_pkg::PH_IDLE;
         end
         default: begin
            phase_in = phase_ff;
         end
      endcase
   end

   // Result of the byte in hand.
   always_comb begin
      emit   = 1'b0;
      result = '0;
      case (phase_ff)
         dcst_pkg::PH_IDLE: begin
            if (byte_in == dcst_pkg::DOC_END_LO || byte_in == dcst_pkg::DOC_END_HI) begin
               emit        = 1'b1;
               result.kind = dcst_pkg::KIND_DOC_END;
            end else if (byte_in == dcst_pkg::HARD_RETURN) begin
               emit        = 1'b1;
               result.kind = dcst_pkg::KIND_PARA_END;
            end else if (byte_in == dcst_pkg::SOFT_RETURN) begin
               emit             = 1'b1;
               result.kind      = dcst_pkg::KIND_TEXT;
               result.char_code = dcst_pkg::CHAR_SPACE;
            end else if (byte_in >= dcst_pkg::TEXT_FIRST && byte_in <= dcst_pkg::TEXT_LAST) begin
               emit             = 1'b1;
               result.kind      = dcst_pkg::KIND_TEXT;
               result.char_code = byte_in;
            end else if (byte_in == dcst_pkg::HARD_HYPHEN) begin
               emit             = 1'b1;
               result.kind      = dcst_pkg::KIND_TEXT;
               result.char_code = dcst_pkg::CHAR_HYPHEN;
            end
         end
         dcst_pkg::PH_FBODY: begin
            emit              = 1'b1;
            result.kind       = dcst_pkg::KIND_BODY;
            result.func_code  = code_ff;
            result.body_index = pos_ff;
            result.body_byte  = byte_in;
         end
         dcst_pkg::PH_FTRAIL: begin
            emit = 1'b1;
            // An extended character from charset 4 can stand for a dash or an apostrophe.
            if (code_ff == dcst_pkg::EXT_CHAR && ext_set_ff == dcst_pkg::EXT_CHARSET
                && ext_code_ff == dcst_pkg::EXT_DASH) begin
               result.kind      = dcst_pkg::KIND_TEXT;
               result.char_code = dcst_pkg::CHAR_HYPHEN;
            end else if (code_ff == dcst_pkg::EXT_CHAR && ext_set_ff == dcst_pkg::EXT_CHARSET
                         && ext_code_ff == dcst_pkg::EXT_APOS) begin
               result.kind      = dcst_pkg::KIND_TEXT;
               result.char_code = dcst_pkg::CHAR_APOS;
            end else begin
               result.kind      = dcst_pkg::KIND_FUNC_END;
               result.func_code = code_ff;
            end
         end
         dcst_pkg::PH_VLENHI: begin
            if (var_len == 16'd0) begin
               emit             = 1'b1;
               result.kind      = dcst_pkg::KIND_FUNC_END;
               result.func_code = code_ff;
               result.sub_code  = sub_ff;
            end
         end
         dcst_pkg::PH_VBODY: begin
            emit              = 1'b1;
            result.kind       = dcst_pkg::KIND_BODY;
            result.func_code  = code_ff;
            result.sub_code   = sub_ff;
            result.body_index = pos_ff;
            result.body_byte  = byte_in;
            result.func_last  = (left_dec == 16'd0);
         end
         default: begin
            emit = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= dcst_pkg::PH_IDLE;
      end else if (step) begin
         phase_ff <= phase_in;
      end
   end

   // Every one of these is loaded before the phase that reads it.
   always_ff @(posedge clock) begin
      if (step) begin
         code_ff     <= code_in;
         sub_ff      <= sub_in;
         len_lo_ff   <= len_lo_in;
         left_ff     <= left_in;
         pos_ff      <= pos_in;
         ext_code_ff <= ext_code_in;
         ext_set_ff  <= ext_set_in;
      end
   end

endmodule

// ===== sv/dcst_out_reg.sv =====
// Result register of the tokenizer: holds one token until the sink takes it.
// Depends on dcst_pkg for the result struct.
module dcst_out_reg (
   input  logic              clock,
   input  logic              reset,
   input  logic              load,
   input  dcst_pkg::rsp_type load_data,
   input  logic              rsp_ready,
   output logic              rsp_valid,
   output logic              free,
   output dcst_pkg::rsp_type rsp_data
);

   logic              vld_ff, vld_in;
   dcst_pkg::rsp_type data_ff;

   // The register can take a new token when empty or when its beat leaves now.
   assign free   = !vld_ff || rsp_ready;
   assign vld_in = load || (vld_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= load_data;
      end
   end

   assign rsp_valid = vld_ff;
   assign rsp_data  = data_ff;

endmodule

// ===== sv/document_code_stream_tokenizer.sv =====
// Document code stream tokenizer: one document byte per beat in, at most one token out.
// A byte accepted into the input register is parsed once the result register is free,
// and its token is loaded into the result register, from which it leaves on rsp.
// Throughput: one byte per cycle; a token held in the result register stalls input.
// Reset (synchronous, active high) empties both registers and returns the parser
// to expecting a code byte; req ready is high once reset has emptied the input register.
module document_code_stream_tokenizer (
   input  logic           clock,
   input  logic           reset,
   dcst_req_if.sink       req_if,
   dcst_rsp_if.source     rsp_if
);

   logic              hold_valid;
   logic [7:0]        hold_byte;
   logic              take;
   logic              emit;
   logic              out_free;
   dcst_pkg::rsp_type result;
   dcst_pkg::rsp_type rsp_data;

   // The held byte is parsed once the result register has room for its token.
   assign take = hold_valid && out_free;

   dcst_in_reg u_in_reg (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_if.valid),
      .req_ready  (req_if.ready),
      .req_byte   (req_if.byte_in),
      .take       (take),
      .hold_valid (hold_valid),
      .hold_byte  (hold_byte)
   );

   dcst_parser u_parser (
      .clock   (clock),
      .reset   (reset),
      .step    (take),
      .byte_in (hold_byte),
      .emit    (emit),
      .result  (result)
   );

   dcst_out_reg u_out_reg (
      .clock     (clock),
      .reset     (reset),
      .load      (take && emit),
      .load_data (result),
      .rsp_ready (rsp_if.ready),
      .rsp_valid (rsp_if.valid),
      .free      (out_free),
      .rsp_data  (rsp_data)
   );

   assign rsp_if.kind       = rsp_data.kind;
   assign rsp_if.char_code  = rsp_data.char_code;
   assign rsp_if.func_code  = rsp_data.func_code;
   assign rsp_if.sub_code   = rsp_data.sub_code;
   assign rsp_if.body_index = rsp_data.body_index;
   assign rsp_if.body_byte  = rsp_data.body_byte;
   assign rsp_if.func_last  = rsp_data.func_last;

endmodule

// ===== sim/dcst_token_check.sv =====
// Token checker for the document code stream tokenizer: watches both channels,
// predicts the token of every accepted byte and compares it with what leaves the block.
// Depends on dcst_pkg.
module dcst_token_check
   import dcst_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [7:0]  req_byte,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [2:0]  rsp_kind,
   input  logic [7:0]  rsp_char_code,
   input  logic [7:0]  rsp_func_code,
   input  logic [7:0]  rsp_sub_code,
   input  logic [15:0] rsp_body_index,
   input  logic [7:0]  rsp_body_byte,
   input  logic        rsp_func_last,
   output int          fail_total,
   output int          tokens_pending
);

   // Body lengths of codes 192..207, four bits each, code 192 in the low nibble.
   localparam logic [63:0] BODY_LENS = {4'd10, 4'd8, 4'd8, 4'd6, 4'd4, 4'd4, 4'd3, 4'd2,
                                        4'd5, 4'd4, 4'd3, 4'd1, 4'd1, 4'd9, 4'd7, 4'd2};

   phase_type   parse_phase;
   logic [7:0]  open_code;
   logic [7:0]  open_sub;
   logic [7:0]  length_lo;
   logic [7:0]  ext_code;
   logic [7:0]  ext_set;
   logic [15:0] body_left;
   logic [15:0] body_pos;
   rsp_type     predicted_tokens [$];
   int          fail_count = 0;

   task automatic tokenize_byte(input logic [7:0] b, output bit made, output rsp_type tok);
      logic [15:0] idx;
      made = 1'b0;
      tok  = '0;
      case (parse_phase)
         PH_IDLE: begin
            if (b == DOC_END_LO || b == DOC_END_HI) begin
               parse_phase = PH_DONE;
               made        = 1'b1;
               tok.kind    = KIND_DOC_END;
            end else if (b == HARD_RETURN) begin
               made     = 1'b1;
               tok.kind = KIND_PARA_END;
            end else if (b == SOFT_RETURN) begin
               made          = 1'b1;
               tok.kind      = KIND_TEXT;
               tok.char_code = CHAR_SPACE;
            end else if (b >= TEXT_FIRST && b <= TEXT_LAST) begin
               made          = 1'b1;
               tok.kind      = KIND_TEXT;
               tok.char_code = b;
            end else if (b == HARD_HYPHEN) begin
               made          = 1'b1;
               tok.kind      = KIND_TEXT;
               tok.char_code = CHAR_HYPHEN;
            end else if (b >= FIXED_FIRST && b <= FIXED_LAST) begin
               open_code   = b;
               open_sub    = '0;
               body_left   = 16'(BODY_LENS[{b[3:0], 2'b00} +: 4]);
               body_pos    = '0;
               ext_code    = '0;
               ext_set     = '0;
               parse_phase = PH_FBODY;
            end else if (b >= VAR_FIRST) begin
               open_code   = b;
               open_sub    = '0;
               parse_phase = PH_VSUB;
            end
         end
         PH_FBODY: begin
            idx = body_pos;
            if (idx == 16'd0) ext_code = b;
            if (idx == 16'd1) ext_set = b;
            body_pos  = body_pos + 16'd1;
            body_left = body_left - 16'd1;
            if (body_left == 16'd0) parse_phase = PH_FTRAIL;
            made           = 1'b1;
            tok.kind       = KIND_BODY;
            tok.func_code  = open_code;
            tok.body_index = idx;
            tok.body_byte  = b;
         end
         PH_FTRAIL: begin
            // The trailer byte itself is never looked at.
            parse_phase = PH_IDLE;
            made        = 1'b1;
            if (open_code == EXT_CHAR && ext_set == EXT_CHARSET && ext_code == EXT_DASH) begin
               tok.kind      = KIND_TEXT;
               tok.char_code = CHAR_HYPHEN;
            end else if (open_code == EXT_CHAR && ext_set == EXT_CHARSET
                         && ext_code == EXT_APOS) begin
               tok.kind      = KIND_TEXT;
               tok.char_code = CHAR_APOS;
            end else begin
               tok.kind      = KIND_FUNC_END;
               tok.func_code = open_code;
            end
         end
         PH_VSUB: begin
            open_sub    = b;
            parse_phase = PH_VLENLO;
         end
         PH_VLENLO: begin
            length_lo   = b;
            parse_phase = PH_VLENHI;
         end
         PH_VLENHI: begin
            body_left = {b, length_lo};
            body_pos  = '0;
            if (body_left == 16'd0) begin
               parse_phase   = PH_IDLE;
               made          = 1'b1;
               tok.kind      = KIND_FUNC_END;
               tok.func_code = open_code;
               tok.sub_code  = open_sub;
            end else begin
               parse_phase = PH_VBODY;
            end
         end
         PH_VBODY: begin
            idx       = body_pos;
            body_pos  = body_pos + 16'd1;
            body_left = body_left - 16'd1;
            made           = 1'b1;
            tok.kind       = KIND_BODY;
            tok.func_code  = open_code;
            tok.sub_code   = open_sub;
            tok.body_index = idx;
            tok.body_byte  = b;
            if (body_left == 16'd0) begin
               parse_phase   = PH_IDLE;
               tok.func_last = 1'b1;
            end
         end
         default: begin
            // After the document end every byte is dropped.
         end
      endcase
   endtask

   task automatic report_token(input string why, input rsp_type want, input rsp_type got);
      fail_count++;
      if (fail_count <= 10) begin
         $display("%0t %s: expected kind %0d char %h func %h sub %h idx %h byte %h last %b",
                  $time, why, want.kind, want.char_code, want.func_code, want.sub_code,
                  want.body_index, want.body_byte, want.func_last);
         $display("%0t %s:      got kind %0d char %h func %h sub %h idx %h byte %h last %b",
                  $time, why, got.kind, got.char_code, got.func_code, got.sub_code,
                  got.body_index, got.body_byte, got.func_last);
      end
   endtask

   always @(posedge clock) begin : watch
      rsp_type got;
      rsp_type want;
      rsp_type tok;
      bit      made;
      if (reset) begin
         parse_phase = PH_IDLE;
         open_code   = '0;
         open_sub    = '0;
         length_lo   = '0;
         body_left   = '0;
         body_pos    = '0;
         ext_code    = '0;
         ext_set     = '0;
         predicted_tokens.delete();
      end else begin
         // Compare before predicting, so a token never meets the byte taken at its own edge.
         if (rsp_valid && rsp_ready) begin
            got.kind       = rsp_kind;
            got.char_code  = rsp_char_code;
            got.func_code  = rsp_func_code;
            got.sub_code   = rsp_sub_code;
            got.body_index = rsp_body_index;
            got.body_byte  = rsp_body_byte;
            got.func_last  = rsp_func_last;
            if (predicted_tokens.size() == 0) begin
               report_token("token with none pending", '0, got);
            end else begin
               want = predicted_tokens.pop_front();
               if (got.kind !== want.kind || got.char_code !== want.char_code
                   || got.func_code !== want.func_code || got.sub_code !== want.sub_code
                   || got.body_index !== want.body_index || got.body_byte !== want.body_byte
                   || got.func_last !== want.func_last)
                  report_token("token mismatch", want, got);
            end
         end
         if (req_valid && req_ready) begin
            tokenize_byte(req_byte, made, tok);
            if (made) predicted_tokens.push_back(tok);
         end
      end
      fail_total     <= fail_count;
      tokens_pending <= predicted_tokens.size();
   end

endmodule

// ===== sim/tb_document_code_stream_tokenizer.sv =====
// Testbench top for the document code stream tokenizer: builds a document byte stream,
// drives it with random idling and back-pressure, and gives the verdict.
// Depends on dcst_pkg, dcst_stream_if, the tokenizer RTL and dcst_token_check.
module tb_document_code_stream_tokenizer;
   import dcst_pkg::*;

   localparam logic [7:0] VAR_LAST        = 8'd254;
   localparam logic [7:0] CTRL_FIRST      = 8'd1;
   localparam logic [7:0] CTRL_LAST       = 8'd31;
   localparam logic [7:0] UPPER_FIRST     = 8'd128;
   localparam logic [7:0] UPPER_LAST      = 8'd191;
   localparam int         RANDOM_ITEMS    = 1400;
   localparam int         HOLD_CYCLES     = 80;

   logic clock = 1'b0;
   logic reset = 1'b1;

   dcst_req_if req_if ();
   dcst_rsp_if rsp_if ();

   logic [7:0] doc_bytes [$];
   int         token_bytes = 0;
   int         long_funcs = 0;
   int         idle_mode = 0;
   int         holds_asked = 0;
   int         fail_total;
   int         tokens_pending;

   always #6 clock = ~clock;

   document_code_stream_tokenizer i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if)
   );

   dcst_token_check i_token_check (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_if.valid),
      .req_ready      (req_if.ready),
      .req_byte       (req_if.byte_in),
      .rsp_valid      (rsp_if.valid),
      .rsp_ready      (rsp_if.ready),
      .rsp_kind       (rsp_if.kind),
      .rsp_char_code  (rsp_if.char_code),
      .rsp_func_code  (rsp_if.func_code),
      .rsp_sub_code   (rsp_if.sub_code),
      .rsp_body_index (rsp_if.body_index),
      .rsp_body_byte  (rsp_if.body_byte),
      .rsp_func_last  (rsp_if.func_last),
      .fail_total     (fail_total),
      .tokens_pending (tokens_pending)
   );

   task automatic put(input logic [7:0] b, input bit counted);
      doc_bytes.push_back(b);
      if (counted) token_bytes++;
   endtask

   // Fixed-length function: the first two body bytes are given, the rest and the
   // trailer are taken as passed or random.
   task automatic put_fixed(input logic [7:0] code, input logic [7:0] first,
                            input logic [7:0] second, input logic [7:0] trailer);
      int n;
      n = int'(fixed_len(code[3:0]));
      put(code, 1'b1);
      for (int i = 0; i < n; i++) begin
         if (i == 0) put(first, 1'b1);
         else if (i == 1) put(second, 1'b1);
         else put(8'($urandom_range(255)), 1'b1);
      end
      put(trailer, 1'b1);
   endtask

   task automatic put_var(input logic [7:0] code, input logic [7:0] sub, input logic [15:0] len);
      put(code, 1'b1);
      put(sub, 1'b1);
      put(len[7:0], 1'b1);
      put(len[15:8], 1'b1);
      for (int i = 0; i < int'(len); i++) put(8'($urandom_range(255)), 1'b1);
   endtask

   task automatic build_document();
      int          sel;
      int          run;
      logic [7:0]  b;
      logic [7:0]  code;
      logic [7:0]  cset;
      logic [15:0] len;
      // Short directed opening: text range ends, the single-byte specials, dropped codes,
      // both extended-character substitutions, zero-length and one-byte functions.
      put(TEXT_FIRST, 1'b1);
      put(TEXT_LAST, 1'b1);
      put(SOFT_RETURN, 1'b1);
      put(HARD_HYPHEN, 1'b1);
      put(HARD_RETURN, 1'b1);
      put(CTRL_FIRST, 1'b0);
      put(UPPER_FIRST, 1'b0);
      put(UPPER_LAST, 1'b0);
      put_fixed(EXT_CHAR, EXT_DASH, EXT_CHARSET, DOC_END_HI);
      put_fixed(EXT_CHAR, EXT_APOS, EXT_CHARSET, DOC_END_LO);
      put_fixed(EXT_CHAR, EXT_DASH, EXT_CHARSET + 8'd1, TEXT_FIRST);
      put_fixed(8'hC3, DOC_END_LO, DOC_END_LO, HARD_RETURN);
      put_var(VAR_FIRST, DOC_END_HI, 16'd0);
      put_var(VAR_LAST, DOC_END_LO, 16'd1);

      // One long body early on so the upper index bits move in every run.
      put_var(8'($urandom_range(VAR_FIRST, VAR_LAST)), 8'($urandom_range(255)),
              16'($urandom_range(256, 400)));
      long_funcs = 1;

      while (token_bytes < RANDOM_ITEMS) begin
         sel = $urandom_range(99);
         if (sel < 30) begin
            run = $urandom_range(1, 8);
            repeat (run) begin
               case ($urandom_range(15))
                  0:       put(SOFT_RETURN, 1'b1);
                  1:       put(HARD_HYPHEN, 1'b1);
                  2:       put(HARD_RETURN, 1'b1);
                  default: put(8'($urandom_range(TEXT_FIRST, TEXT_LAST)), 1'b1);
               endcase
            end
         end else if (sel < 50) begin
            put_fixed(8'($urandom_range(FIXED_FIRST, FIXED_LAST)), 8'($urandom_range(255)),
                      8'($urandom_range(255)), 8'($urandom_range(255)));
         end else if (sel < 60) begin
            case ($urandom_range(2))
               0:       code = EXT_DASH;
               1:       code = EXT_APOS;
               default: code = 8'($urandom_range(255));
            endcase
            cset = ($urandom_range(3) != 0) ? EXT_CHARSET : 8'($urandom_range(255));
            put_fixed(EXT_CHAR, code, cset, 8'($urandom_range(255)));
         end else if (sel < 85) begin
            if (long_funcs < 3 && $urandom_range(49) == 0) begin
               len = 16'($urandom_range(256, 700));
               long_funcs++;
            end else begin
               len = 16'($urandom_range(12));
            end
            put_var(8'($urandom_range(VAR_FIRST, VAR_LAST)), 8'($urandom_range(255)), len);
         end else if ($urandom_range(3) == 0) begin
            put(HARD_RETURN, 1'b1);
         end else begin
            // Codes that the block drops without a token.
            do begin
               b = $urandom_range(1) ? 8'($urandom_range(CTRL_FIRST, CTRL_LAST))
                                     : 8'($urandom_range(UPPER_FIRST, UPPER_LAST));
            end while (b == HARD_RETURN || b == SOFT_RETURN || b == HARD_HYPHEN);
            put(b, 1'b0);
         end
      end

      // The document end comes once, last; whatever follows it must be ignored.
      put($urandom_range(1) ? DOC_END_HI : DOC_END_LO, 1'b1);
      repeat (10) put(8'($urandom_range(255)), 1'b0);
   endtask

   initial begin : sender
      int total;
      int pct;
      int mode;
      int wait_cycles;
      req_if.valid   <= 1'b0;
      req_if.byte_in <= '0;
      build_document();
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      total = doc_bytes.size();
      mode  = 0;
      for (int i = 0; i < total; i++) begin
         if (i == total / 3) begin
            // Drain completely before the idling pattern flips.
            req_if.valid <= 1'b0;
            do @(posedge clock); while (tokens_pending != 0);
            mode = 1;
            idle_mode <= 1;
         end else if (i == 2 * total / 3) begin
            mode = 2;
            idle_mode <= 2;
            holds_asked <= holds_asked + 1;
         end
         pct = (mode == 0) ? 25 : (mode == 1) ? 50 : 0;
         if (pct != 0 && $urandom_range(99) < pct) begin
            req_if.valid <= 1'b0;
            do @(posedge clock); while ($urandom_range(99) < pct);
         end
         req_if.valid   <= 1'b1;
         req_if.byte_in <= doc_bytes[i];
         do @(posedge clock); while (!req_if.ready);
      end
      req_if.valid <= 1'b0;

      wait_cycles = 0;
      do begin
         @(posedge clock);
         wait_cycles++;
      end while (tokens_pending != 0 && wait_cycles < 2000);
      repeat (20) @(posedge clock);
      if (fail_total == 0 && tokens_pending == 0)
         $display("tb_document_code_stream_tokenizer passed");
      else
         $display("tb_document_code_stream_tokenizer failed");
      $finish;
   end

   initial begin : receiver
      int hold_left;
      int holds_seen;
      int pct;
      hold_left  = 0;
      holds_seen = 0;
      rsp_if.ready <= 1'b0;
      forever begin
         @(posedge clock);
         pct = (idle_mode == 0) ? 50 : (idle_mode == 1) ? 25 : 0;
         if (hold_left != 0) begin
            rsp_if.ready <= 1'b0;
            hold_left--;
         end else if (holds_seen != holds_asked) begin
            // Long hold-off while the sender keeps going, so the block backs up.
            holds_seen = holds_asked;
            hold_left  = HOLD_CYCLES;
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= (pct == 0) || ($urandom_range(99) >= pct);
         end
      end
   end

   initial begin : watchdog
      #6000000;
      $display("tb_document_code_stream_tokenizer failed");
      $finish;
   end

endmodule
